### sv/ffha_pkg.sv
// Shared constants, codes and helpers of the first-fit heap allocator.
package ffha_pkg;

	// chunk header and size rounding
	localparam int unsigned HEADER_BYTES = 8;
	localparam int unsigned HDR_SHIFT    = 3;
	localparam int unsigned MIN_CHUNK    = 3 * HEADER_BYTES;
	localparam logic [16:0] ROUND_MASK   = 17'h0000f;

	// field widths of the request and result
	localparam int unsigned REQ_W = 16;
	localparam int unsigned OFF_W = 16;
	localparam int unsigned GSZ_W = 17;

	// request kinds
	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_REALLOC = 2'd2,
		CMD_RSVD    = 2'd3
	} cmd_t;

	// field touched by a read-modify-write of a metadata entry
	typedef enum logic [1:0] {
		F_NEXT = 2'd0,
		F_PREV = 2'd1,
		F_SIZE = 2'd2,
		F_PUSH = 2'd3
	} fld_t;

	// chunk size for a user request, header included
	function automatic logic [16:0] round_need(input logic [REQ_W-1:0] req);
		logic [16:0] t;
		logic [16:0] r;
		t = {1'b0, req} + 17'(HEADER_BYTES);
		if (t <= 17'(MIN_CHUNK)) begin
			r = 17'(MIN_CHUNK);
		end else begin
			r = (t + ROUND_MASK) & ~ROUND_MASK;
		end
		return r;
	endfunction

endpackage

### sv/ffha_ram.sv
// Single-port-write, single-port-read metadata RAM with registered read data.
module ffha_ram #(
	parameter int unsigned DEPTH = 8192,
	parameter int unsigned WIDTH = 45,
	parameter int unsigned AW    = 13
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### sv/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: request sequencer over the metadata RAM.
//
// Requests arrive on s_axis: tuser carries the command (allocate, free, reallocate),
// tdata the requested byte count and the user offset of an existing block. Each
// request gives exactly one result on m_axis: tuser is the status (0 ok, 1 out of
// memory), tdata the granted user offset and the granted chunk size.
// All chunk metadata (size, next and prev link) sits in one RAM entry per slot;
// the list head and tail live in registers. Each link update but a split remainder's
// write is a read and a write-back of one entry, in turn, so no two accesses overlap.
// A free pushes the chunk onto the free-list head; an allocate walks the free list
// first fit, then unlinks the chunk found and splits off any remainder; a reallocate
// first checks the old chunk in place and frees it only after a new grant.
// One request is handled at a time; the walk over the RAM read port sets the rate.
// After reset the block sweeps the RAM, one entry a cycle, and holds s_axis_tready
// low until the sweep is done.
// The result sits in an output register; the next request is taken while it
// waits, and a finished result waits in its last step while m_axis stalls.
module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int unsigned HEAP_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] request_size, [31:16] block_offset
	input  logic [1:0]  s_axis_tuser,  // [1:0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [15:0] result_offset, [32:16] granted_size
	output logic        m_axis_tuser   // [0] status
);

	localparam int unsigned SLOTS = HEAP_BYTES / HEADER_BYTES;
	localparam int unsigned IW    = $clog2(SLOTS);
	localparam int unsigned LW    = $clog2(SLOTS + 1);
	localparam int unsigned SW    = $clog2(HEAP_BYTES + 1);
	localparam int unsigned CW    = (SW > GSZ_W) ? SW : GSZ_W;
	localparam int unsigned PW    = ((IW > 14) ? IW : 14) + 1;
	localparam int unsigned EW    = SW + 2 * LW;
	localparam logic [LW-1:0] SENT = LW'(SLOTS);

	typedef struct packed {
		logic [SW-1:0] size;
		logic [LW-1:0] nxt;
		logic [LW-1:0] prv;
	} ent_t;

	typedef enum logic [16:0] {
		S_CLEAR    = 17'h00001,
		S_IDLE     = 17'h00002,
		S_SLOT     = 17'h00004,
		S_RSZ      = 17'h00008,
		S_CMP      = 17'h00010,
		S_WALK_RD  = 17'h00020,
		S_WALK_CK  = 17'h00040,
		S_UNL_P    = 17'h00080,
		S_UNL_N    = 17'h00100,
		S_SPL_CUR  = 17'h00200,
		S_SPL_LEFT = 17'h00400,
		S_SPL_TAIL = 17'h00800,
		S_GRANT    = 17'h01000,
		S_PF_E     = 17'h02000,
		S_PF_H     = 17'h04000,
		S_RMW_RD   = 17'h08000,
		S_RMW_WR   = 17'h10000
	} state_t;

	// user offset to slot: (offset - header) mod 2^16, divided, mod SLOTS
	function automatic logic [IW-1:0] slot_of(input logic [OFF_W-1:0] boff);
		logic [OFF_W-1:0] coff;
		logic [23:0]      x;
		coff = boff - OFF_W'(HEADER_BYTES);
		x    = 24'(coff >> HDR_SHIFT);
		for (int k = 5; k >= 0; k--) begin
			if (x >= (24'(SLOTS) << k)) begin
				x = x - (24'(SLOTS) << k);
			end
		end
		return x[IW-1:0];
	endfunction

	state_t            state_q;
	state_t            ret_q;
	cmd_t              cmd_q;
	logic [REQ_W-1:0]  req_q;
	logic [OFF_W-1:0]  boff_q;
	logic [16:0]       need_q;
	logic [IW-1:0]     old_q;
	logic [LW-1:0]     cur_q;
	logic [LW-1:0]     steps_q;
	logic [LW-1:0]     head_q;
	logic [LW-1:0]     tail_q;
	logic [LW-1:0]     fp_q;
	logic [LW-1:0]     fn_q;
	logic [CW-1:0]     fsz_q;
	logic [CW-1:0]     rem_q;
	logic [IW-1:0]     left_q;
	logic              split_q;
	logic [IW-1:0]     clr_q;
	logic [IW-1:0]     rmw_addr_q;
	fld_t              rmw_fld_q;
	logic [CW-1:0]     rmw_val_q;
	logic              res_status_q;
	logic [OFF_W-1:0]  res_off_q;
	logic [GSZ_W-1:0]  res_size_q;
	logic              out_valid_q;
	logic              out_status_q;
	logic [OFF_W-1:0]  out_off_q;
	logic [GSZ_W-1:0]  out_size_q;

	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	logic [EW-1:0]     mem_wdata;
	logic [IW-1:0]     mem_raddr;
	logic [EW-1:0]     mem_rdata;
	ent_t              rd_ent;
	ent_t              mod_ent;
	ent_t              clr_ent;
	logic              s_acc;
	logic              out_free;
	logic              out_load;
	logic [CW-1:0]     rd_size;
	logic [CW-1:0]     rem_now;
	logic [PW-1:0]     left_sum;
	logic [IW-1:0]     left_now;
	logic [23:0]       cur_off;

	ffha_ram #(
		.DEPTH(SLOTS),
		.WIDTH(EW),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rd_ent   = ent_t'(mem_rdata);
	assign rd_size  = CW'(rd_ent.size);
	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	// output register loads a new result this cycle
	assign out_load = (state_q == S_GRANT) && out_free
		&& !(ret_q == S_PF_E && cmd_q == CMD_REALLOC);

	// split arithmetic on the chunk found by the walk
	assign rem_now  = fsz_q - CW'(need_q);
	assign left_sum = PW'(cur_q[IW-1:0]) + PW'(need_q >> HDR_SHIFT);
	assign left_now = (left_sum >= PW'(SLOTS)) ? IW'(left_sum - PW'(SLOTS))
		: left_sum[IW-1:0];
	assign cur_off  = (24'(cur_q[IW-1:0]) << HDR_SHIFT) + 24'(HEADER_BYTES);

	// RAM read address
	always_comb begin
		unique case (state_q)
			S_RSZ:    mem_raddr = old_q;
			S_RMW_RD: mem_raddr = rmw_addr_q;
			default:  mem_raddr = cur_q[IW-1:0];
		endcase
	end

	// entry after a read-modify-write
	always_comb begin
		mod_ent = rd_ent;
		case (rmw_fld_q)
			F_NEXT: mod_ent.nxt = rmw_val_q[LW-1:0];
			F_PREV: mod_ent.prv = rmw_val_q[LW-1:0];
			F_SIZE: mod_ent.size = rmw_val_q[SW-1:0];
			default: begin
				mod_ent.nxt = rmw_val_q[LW-1:0];
				mod_ent.prv = SENT;
			end
		endcase
	end

	// reset image: slot 0 spans the heap, the rest is zero
	always_comb begin
		clr_ent = '0;
		if (clr_q == '0) begin
			clr_ent.size = SW'(HEAP_BYTES);
			clr_ent.nxt  = SENT;
			clr_ent.prv  = SENT;
		end
	end

	// RAM write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rmw_addr_q;
		mem_wdata = EW'(mod_ent);
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = EW'(clr_ent);
			end
			S_SPL_LEFT: begin
				mem_we    = 1'b1;
				mem_waddr = left_q;
				mem_wdata = {SW'(rem_q), SENT, tail_q};
			end
			S_RMW_WR: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			ret_q        <= S_IDLE;
			cmd_q        <= CMD_ALLOC;
			req_q        <= '0;
			boff_q       <= '0;
			need_q       <= '0;
			old_q        <= '0;
			cur_q        <= '0;
			steps_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			fp_q         <= '0;
			fn_q         <= '0;
			fsz_q        <= '0;
			rem_q        <= '0;
			left_q       <= '0;
			split_q      <= 1'b0;
			clr_q        <= '0;
			rmw_addr_q   <= '0;
			rmw_fld_q    <= F_NEXT;
			rmw_val_q    <= '0;
			res_status_q <= 1'b0;
			res_off_q    <= '0;
			res_size_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= 1'b0;
			out_off_q    <= '0;
			out_size_q   <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_acc) begin
						cmd_q        <= cmd_t'(s_axis_tuser);
						req_q        <= s_axis_tdata[15:0];
						boff_q       <= s_axis_tdata[31:16];
						need_q       <= round_need(s_axis_tdata[15:0]);
						res_status_q <= 1'b0;
						res_off_q    <= '0;
						res_size_q   <= '0;
						cur_q        <= head_q;
						steps_q      <= '0;
						split_q      <= 1'b0;
						case (cmd_t'(s_axis_tuser)) inside
							CMD_ALLOC:                state_q <= S_WALK_RD;
							CMD_FREE, CMD_REALLOC:    state_q <= S_SLOT;
							default:                  state_q <= S_GRANT;
						endcase
						// unknown command goes straight to the result
						if (cmd_t'(s_axis_tuser) == CMD_RSVD) begin
							ret_q <= S_IDLE;
						end
					end
				end
				S_SLOT: begin
					old_q   <= slot_of(boff_q);
					state_q <= (cmd_q == CMD_FREE) ? S_PF_E : S_RSZ;
				end
				S_RSZ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (rd_size >= CW'(req_q)) begin
						res_off_q  <= boff_q;
						res_size_q <= rd_size[GSZ_W-1:0];
						state_q    <= S_GRANT;
						ret_q      <= S_IDLE;
					end else begin
						cur_q   <= head_q;
						steps_q <= '0;
						state_q <= S_WALK_RD;
					end
				end
				S_WALK_RD: begin
					if (cur_q >= SENT || steps_q == LW'(SLOTS)) begin
						res_status_q <= 1'b1;
						res_off_q    <= '0;
						res_size_q   <= '0;
						state_q      <= S_GRANT;
						ret_q        <= S_IDLE;
					end else begin
						state_q <= S_WALK_CK;
					end
				end
				S_WALK_CK: begin
					if (rd_size >= CW'(need_q)) begin
						fp_q    <= rd_ent.prv;
						fn_q    <= rd_ent.nxt;
						fsz_q   <= rd_size;
						state_q <= S_UNL_P;
					end else begin
						cur_q   <= rd_ent.nxt;
						steps_q <= steps_q + 1'b1;
						state_q <= S_WALK_RD;
					end
				end
				// unlink: prev.next = next
				S_UNL_P: begin
					if (fp_q >= SENT) begin
						head_q  <= fn_q;
						state_q <= S_UNL_N;
					end else begin
						rmw_addr_q <= fp_q[IW-1:0];
						rmw_fld_q  <= F_NEXT;
						rmw_val_q  <= CW'(fn_q);
						ret_q      <= S_UNL_N;
						state_q    <= S_RMW_RD;
					end
				end
				// unlink: next.prev = prev
				S_UNL_N: begin
					if (fn_q >= SENT) begin
						tail_q  <= fp_q;
						state_q <= S_SPL_CUR;
					end else begin
						rmw_addr_q <= fn_q[IW-1:0];
						rmw_fld_q  <= F_PREV;
						rmw_val_q  <= CW'(fp_q);
						ret_q      <= S_SPL_CUR;
						state_q    <= S_RMW_RD;
					end
				end
				// shrink the found chunk when the remainder is worth keeping
				S_SPL_CUR: begin
					rem_q  <= rem_now;
					left_q <= left_now;
					if (rem_now >= CW'(MIN_CHUNK)) begin
						split_q    <= 1'b1;
						rmw_addr_q <= cur_q[IW-1:0];
						rmw_fld_q  <= F_SIZE;
						rmw_val_q  <= CW'(need_q);
						ret_q      <= S_SPL_LEFT;
						state_q    <= S_RMW_RD;
					end else begin
						state_q <= S_GRANT;
						ret_q   <= S_PF_E;
					end
				end
				S_SPL_LEFT: begin
					state_q <= S_SPL_TAIL;
				end
				// append the remainder at the tail
				S_SPL_TAIL: begin
					tail_q <= LW'(left_q);
					if (tail_q >= SENT) begin
						head_q  <= LW'(left_q);
						state_q <= S_GRANT;
					end else begin
						rmw_addr_q <= tail_q[IW-1:0];
						rmw_fld_q  <= F_NEXT;
						rmw_val_q  <= CW'(left_q);
						state_q    <= S_RMW_RD;
					end
					ret_q <= S_PF_E;
				end
				// publish the result; reallocate still frees the old chunk
				S_GRANT: begin
					if (ret_q == S_PF_E) begin
						res_off_q  <= cur_off[OFF_W-1:0];
						res_size_q <= split_q ? need_q : fsz_q[GSZ_W-1:0];
					end
					if (ret_q == S_PF_E && cmd_q == CMD_REALLOC) begin
						state_q <= S_PF_E;
						ret_q   <= S_IDLE;
					end else if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_off_q    <= (ret_q == S_PF_E) ? cur_off[OFF_W-1:0] : res_off_q;
						out_size_q   <= (ret_q == S_PF_E)
							? (split_q ? need_q : fsz_q[GSZ_W-1:0]) : res_size_q;
						state_q      <= S_IDLE;
					end else if (ret_q == S_PF_E) begin
						ret_q <= S_IDLE;
					end
				end
				// push front: old.next = head, old.prev = sentinel
				S_PF_E: begin
					rmw_addr_q <= old_q;
					rmw_fld_q  <= F_PUSH;
					rmw_val_q  <= CW'(head_q);
					ret_q      <= S_PF_H;
					state_q    <= S_RMW_RD;
				end
				// push front: head.prev = old, head = old
				S_PF_H: begin
					head_q <= LW'(old_q);
					ret_q  <= S_IDLE;
					if (head_q >= SENT) begin
						tail_q  <= LW'(old_q);
						state_q <= S_GRANT;
					end else begin
						rmw_addr_q <= head_q[IW-1:0];
						rmw_fld_q  <= F_PREV;
						rmw_val_q  <= CW'(old_q);
						state_q    <= S_RMW_RD;
					end
				end
				S_RMW_RD: begin
					state_q <= S_RMW_WR;
				end
				// a finished grant or free returns to the result step
				S_RMW_WR: begin
					state_q <= (ret_q == S_IDLE || ret_q == S_PF_E) ? S_GRANT : ret_q;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {7'b0, out_size_q, out_off_q};

	// no metadata write while waiting for a request
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("metadata written while idle");

	// the walk never inspects the sentinel
	a_walk_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK_CK) |-> (cur_q < SENT))
		else $error("walk reached sentinel entry");

	// the walk is bounded by the slot count
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= LW'(SLOTS))
		else $error("walk step count overflow");

	// a pending result is never overwritten before it is taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result overwritten while stalled");

endmodule

### dv/ffha_checker.sv
// Checker for the first-fit heap allocator: predicts each result and compares it.
`timescale 1ns / 1ps
module ffha_checker
	import ffha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	output int          fail_count,
	output int          pending
);

	localparam int unsigned NSLOT = 8192;
	localparam logic [13:0] SENT  = 14'd8192;
	localparam logic [16:0] HEAP  = 17'h10000;

	typedef struct packed {
		logic        status;
		logic [15:0] offset;
		logic [16:0] gsize;
	} alloc_result_t;

	// shadow copy of the chunk metadata and free list
	logic [16:0] size_mem [NSLOT];
	logic [13:0] next_mem [NSLOT];
	logic [13:0] prev_mem [NSLOT];
	logic [13:0] head;
	logic [13:0] tail;

	alloc_result_t expected_results[$];

	assign pending = expected_results.size();

	function automatic logic [13:0] link_next(logic [13:0] n);
		return (n < SENT) ? next_mem[n[12:0]] : head;
	endfunction

	function automatic logic [13:0] link_prev(logic [13:0] n);
		return (n < SENT) ? prev_mem[n[12:0]] : tail;
	endfunction

	function automatic void set_next(logic [13:0] n, logic [13:0] v);
		if (n < SENT) next_mem[n[12:0]] = v;
		else head = v;
	endfunction

	function automatic void set_prev(logic [13:0] n, logic [13:0] v);
		if (n < SENT) prev_mem[n[12:0]] = v;
		else tail = v;
	endfunction

	function automatic void push_head(logic [13:0] e);
		set_next(e, link_next(SENT));
		set_prev(e, SENT);
		set_prev(link_next(SENT), e);
		set_next(SENT, e);
	endfunction

	function automatic void push_tail(logic [13:0] e);
		set_prev(e, link_prev(SENT));
		set_next(e, SENT);
		set_next(link_prev(SENT), e);
		set_prev(SENT, e);
	endfunction

	function automatic void unlink(logic [13:0] e);
		set_next(link_prev(e), link_next(e));
		set_prev(link_next(e), link_prev(e));
	endfunction

	// chunk size needed for a user request, header included
	function automatic logic [16:0] chunk_need(logic [15:0] req);
		logic [16:0] t;
		t = {1'b0, req} + 17'd8;
		if (t <= 17'd24) return 17'd24;
		return (t + 17'hf) & ~17'hf;
	endfunction

	// first-fit search, unlink and split; walk bounded by the slot count
	function automatic logic first_fit(logic [15:0] req, output logic [13:0] slot,
			output logic [16:0] gsz);
		logic [16:0] need;
		logic [13:0] cur;
		logic [16:0] rem;
		logic [13:0] rest;
		need = chunk_need(req);
		cur  = link_next(SENT);
		slot = '0;
		gsz  = '0;
		for (int steps = 0; steps < NSLOT && cur < SENT; steps++) begin
			if (size_mem[cur[12:0]] >= need) begin
				rem = size_mem[cur[12:0]] - need;
				unlink(cur);
				if (rem >= 17'd24) begin
					rest = {1'b0, 13'(cur + need[16:3])};
					size_mem[rest[12:0]] = rem;
					size_mem[cur[12:0]]  = need;
					push_tail(rest);
				end
				slot = cur;
				gsz  = size_mem[cur[12:0]];
				return 1'b1;
			end
			cur = link_next(cur);
		end
		return 1'b0;
	endfunction

	function automatic logic [13:0] user_slot(logic [15:0] boff);
		logic [15:0] coff;
		coff = boff - 16'd8;
		return {1'b0, coff[15:3]};
	endfunction

	function automatic alloc_result_t predict_request(cmd_t c, logic [15:0] req,
			logic [15:0] boff);
		alloc_result_t r;
		logic [13:0] slot;
		logic [16:0] gsz;
		logic [13:0] old;
		r = '0;
		case (c)
			CMD_ALLOC: begin
				if (first_fit(req, slot, gsz)) begin
					r.offset = 16'({slot, 3'b000} + 17'd8);
					r.gsize  = gsz;
				end else begin
					r.status = 1'b1;
				end
			end
			CMD_FREE: begin
				push_head(user_slot(boff));
			end
			CMD_REALLOC: begin
				old = user_slot(boff);
				if (size_mem[old[12:0]] >= {1'b0, req}) begin
					r.offset = boff;
					r.gsize  = size_mem[old[12:0]];
				end else if (first_fit(req, slot, gsz)) begin
					push_head(old);
					r.offset = 16'({slot, 3'b000} + 17'd8);
					r.gsize  = gsz;
				end else begin
					r.status = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// predict on each accepted request, compare on each accepted result
	always @(posedge clk or negedge arst_n) begin
		alloc_result_t got;
		alloc_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				size_mem[i] = '0;
				next_mem[i] = '0;
				prev_mem[i] = '0;
			end
			size_mem[0] = HEAP;
			next_mem[0] = SENT;
			prev_mem[0] = SENT;
			head = '0;
			tail = '0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(predict_request(cmd_t'(s_axis_tuser),
					s_axis_tdata[15:0], s_axis_tdata[31:16]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tuser;
				got.offset = m_axis_tdata[15:0];
				got.gsize  = m_axis_tdata[32:16];
				if (expected_results.size() == 0) begin
					$error("result with no request waiting: status %0d offset %0h size %0h",
						got.status, got.offset, got.gsize);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						fail_count++;
					end
					if (got.offset !== want.offset) begin
						$error("result_offset: expected %0h, actual %0h",
							want.offset, got.offset);
						fail_count++;
					end
					if (got.gsize !== want.gsize) begin
						$error("granted_size: expected %0h, actual %0h", want.gsize, got.gsize);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

### dv/first_fit_heap_allocator_tb.sv
// Testbench top for the first-fit heap allocator: stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps
module first_fit_heap_allocator_tb;
	import ffha_pkg::*;

	localparam int RANDOM_REQS = 1380;
	localparam int NOISE_REQS  = 20;
	localparam int CYCLE_LIMIT = 100000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = CMD_ALLOC;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;

	int          fail_count;
	int          pending;
	int          cycles = 0;
	int          burst_left = 0;
	logic        track_live = 1'b0;
	logic        long_hold = 1'b0;
	logic [15:0] live_blocks[$];

	first_fit_heap_allocator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	ffha_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always #5 clk = ~clk;

	// run-time guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// granted blocks become candidates for later free and reallocate requests
	always @(posedge clk) begin
		if (track_live && m_axis_tvalid && m_axis_tready && !m_axis_tuser
				&& m_axis_tdata[32:16] != '0)
			live_blocks.push_back(m_axis_tdata[15:0]);
	end

	// receiver: stall phases of random style and length, plus one long hold
	initial begin
		int mode;
		int span;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (600) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 300);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 1) == 0);
					2: m_axis_tready <= ($urandom_range(0, 5) == 0);
					default: m_axis_tready <= ($urandom_range(0, 5) != 0);
				endcase
			end
		end
	end

	// offer one request and hold it until taken; gaps between bursts
	task automatic send_request(cmd_t c, logic [15:0] req, logic [15:0] boff);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= c;
		s_axis_tdata  <= {boff, req};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end else begin
			burst_left--;
		end
	endtask

	function automatic logic [15:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return 16'($urandom_range(0, 256));
		if (r < 97) return 16'($urandom_range(257, 4096));
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] take_live();
		int idx;
		logic [15:0] b;
		idx = $urandom_range(0, live_blocks.size() - 1);
		b = live_blocks[idx];
		live_blocks.delete(idx);
		return b;
	endfunction

	initial begin
		int r;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: size rounding edges, out of memory, free, realloc cases, reserved code
		send_request(CMD_ALLOC, 16'd0, 16'hffff);
		send_request(CMD_ALLOC, 16'd16, 16'h0000);
		send_request(CMD_ALLOC, 16'd17, 16'h5555);
		send_request(CMD_ALLOC, 16'hffff, 16'haaaa);
		send_request(CMD_ALLOC, 16'd100, 16'd0);
		send_request(CMD_FREE, 16'hffff, 16'd8);
		send_request(CMD_REALLOC, 16'd8, 16'd32);
		send_request(CMD_REALLOC, 16'd200, 16'd56);
		send_request(CMD_REALLOC, 16'd0, 16'd88);
		send_request(CMD_REALLOC, 16'hffff, 16'd88);
		send_request(CMD_RSVD, 16'hffff, 16'hffff);
		send_request(CMD_RSVD, 16'd0, 16'd0);
		send_request(CMD_ALLOC, 16'd65528, 16'd0);
		send_request(CMD_ALLOC, 16'd0, 16'd0);
		send_request(CMD_ALLOC, 16'd30000, 16'd0);
		send_request(CMD_ALLOC, 16'd40000, 16'd0);

		// random well-formed traffic over the blocks actually granted
		track_live = 1'b1;
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i == RANDOM_REQS / 2) long_hold = 1'b1;
			r = $urandom_range(0, 99);
			if (live_blocks.size() > 60) r = r + 30;
			if (live_blocks.size() == 0 || r < 50)
				send_request(CMD_ALLOC, pick_size(), 16'($urandom));
			else if (r < 100)
				send_request(CMD_FREE, 16'($urandom), take_live());
			else
				send_request(CMD_REALLOC, pick_size(), take_live());
		end

		// untrusted offsets and unknown codes last, since they can corrupt the list
		track_live = 1'b0;
		send_request(CMD_FREE, 16'h0, 16'h0);
		send_request(CMD_ALLOC, 16'd3000, 16'h0);
		for (int i = 0; i < NOISE_REQS; i++)
			send_request(cmd_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));

		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
